[sv/ucnv_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-16 newline converter package
// Shared types, constants and helper functions for the converter.
// ----------------------------------------------------------------------------
package ucnv_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 2;
   localparam int CONV_W  = 2;
   localparam int CODE_W  = 16;

   localparam logic [BYTE_W-1:0]  BOM_FIRST  = 8'hFF;
   localparam logic [BYTE_W-1:0]  BOM_SECOND = 8'hFE;
   localparam logic [CODE_W-1:0]  CODE_CR    = 16'h000D;
   localparam logic [CODE_W-1:0]  CODE_LF    = 16'h000A;

   localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWAP   = 2'd2;

   typedef enum logic [CONV_W-1:0] {
      CONV_UNIX = 2'd0,
      CONV_MAC  = 2'd1,
      CONV_WIN  = 2'd2
   } conv_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  first_byte;
      logic [BYTE_W-1:0]  second_byte;
      logic [COUNT_W-1:0] byte_count;
      logic               stream_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_first_byte;
      logic [BYTE_W-1:0]  out_second_byte;
      logic [COUNT_W-1:0] out_byte_count;
      logic               last_of_run;
      logic               end_marker;
   } rsp_type;

   typedef struct packed {
      logic [CONV_W-1:0] source_convention;
      logic [CONV_W-1:0] dest_convention;
      logic              swap_order;
   } cfg_type;

   // Results of one request, ready to load into the output buffer
   typedef struct packed {
      logic               load;
      logic [COUNT_W-1:0] count;
      rsp_type            res0;
      rsp_type            res1;
   } bundle_type;

   // Unused code three reads as unix
   function automatic conv_type conv_of(input logic [CONV_W-1:0] v);
      conv_type c;
      case (v)
         CONV_MAC: c = CONV_MAC;
         CONV_WIN: c = CONV_WIN;
         default:  c = CONV_UNIX;
      endcase
      return c;
   endfunction

   // Place two bytes, swapped on request, as a full unit
   function automatic rsp_type make_pair(input logic [BYTE_W-1:0] a,
                                         input logic [BYTE_W-1:0] b,
                                         input logic swap);
      rsp_type r;
      r.out_first_byte  = swap ? b : a;
      r.out_second_byte = swap ? a : b;
      r.out_byte_count  = COUNT_TWO;
      r.last_of_run     = 1'b0;
      r.end_marker      = 1'b0;
      return r;
   endfunction

   // Write a code in stream byte order, then swap on request
   function automatic rsp_type make_code(input logic [CODE_W-1:0] code,
                                         input logic le,
                                         input logic swap);
      rsp_type r;
      if (le) begin
         r = make_pair(code[7:0], code[15:8], swap);
      end else begin
         r = make_pair(code[15:8], code[7:0], swap);
      end
      return r;
   endfunction

endpackage

[sv/ucnv_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one UTF-16 code unit.
// ----------------------------------------------------------------------------
interface ucnv_req_if;
   logic                            valid;
   logic                            ready;
   logic [ucnv_pkg::BYTE_W-1:0]     first_byte;
   logic [ucnv_pkg::BYTE_W-1:0]     second_byte;
   logic [ucnv_pkg::COUNT_W-1:0]    byte_count;
   logic                            stream_end;

   modport source (output valid, first_byte, second_byte, byte_count, stream_end,
                   input ready);
   modport sink   (input valid, first_byte, second_byte, byte_count, stream_end,
                   output ready);
endinterface

[sv/ucnv_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one emitted code unit.
// ----------------------------------------------------------------------------
interface ucnv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ucnv_pkg::BYTE_W-1:0]     out_first_byte;
   logic [ucnv_pkg::BYTE_W-1:0]     out_second_byte;
   logic [ucnv_pkg::COUNT_W-1:0]    out_byte_count;
   logic                            last_of_run;
   logic                            end_marker;

   modport source (output valid, out_first_byte, out_second_byte, out_byte_count,
                   last_of_run, end_marker, input ready);
   modport sink   (input valid, out_first_byte, out_second_byte, out_byte_count,
                   last_of_run, end_marker, output ready);
endinterface

[sv/utf16_newline_converter.sv]
// ----------------------------------------------------------------------------
// UTF-16 newline converter
// Rewrites LF / CR / CR LF newlines of a UTF-16 stream, optional byte swap.
// ----------------------------------------------------------------------------
//   channel  direction  carries
//   req      in         one code unit (two bytes or a lone byte), stream end
//   rsp      out        one emitted unit, last-of-run and end-of-stream flags
//   csr      in         register writes: source, dest, swap
//
// A request is registered in the input register, then is converted and
// loaded into a two-entry output buffer. One request per cycle is sustained
// while each yields at most one unit and the response side is ready; a request
// that yields two units holds the input while the buffer drains.
// Reset clears the conventions, swap, byte order and held CR state.
// ----------------------------------------------------------------------------
module utf16_newline_converter (
   input  logic                               clock,
   input  logic                               reset,
   ucnv_req_if.sink                           req,
   ucnv_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [ucnv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ucnv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ucnv_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       item_valid;
   req_type    item;
   logic       take;
   logic       out_free;
   bundle_type bundle;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SOURCE: cfg_in.source_convention = csr_wdata[CONV_W-1:0];
            CSR_DEST:   cfg_in.dest_convention   = csr_wdata[CONV_W-1:0];
            CSR_SWAP:   cfg_in.swap_order        = csr_wdata[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ucnv_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ucnv_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .cfg        (cfg_ff),
      .out_free   (out_free),
      .take       (take),
      .bundle     (bundle)
   );

   ucnv_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .bundle   (bundle),
      .out_free (out_free),
      .rsp      (rsp)
   );
endmodule

[sv/ucnv_in_stage.sv]
// ----------------------------------------------------------------------------
// Input register
// Captures one request and holds it until the converter takes it.
// ----------------------------------------------------------------------------
module ucnv_in_stage (
   input  logic              clock,
   input  logic              reset,
   ucnv_req_if.sink          req,
   input  logic              take,
   output logic              item_valid,
   output ucnv_pkg::req_type item
);
   import ucnv_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;
   logic    accept;

   assign req.ready = !valid_ff || take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in            = 1'b1;
         item_in.first_byte  = req.first_byte;
         item_in.second_byte = req.second_byte;
         item_in.byte_count  = req.byte_count;
         item_in.stream_end  = req.stream_end;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

[sv/ucnv_conv.sv]
// ----------------------------------------------------------------------------
// Newline conversion
// Byte order detection, CR holding and newline rewrite for one request.
// ----------------------------------------------------------------------------
module ucnv_conv (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  ucnv_pkg::req_type    item,
   input  ucnv_pkg::cfg_type    cfg,
   input  logic                 out_free,
   output logic                 take,
   output ucnv_pkg::bundle_type bundle
);
   import ucnv_pkg::*;

   logic seen_ff, seen_in;
   logic le_ff, le_in;
   logic held_ff, held_in;

   conv_type           s, d;
   logic               le, held, done, is_two;
   logic [COUNT_W-1:0] n;
   logic [CODE_W-1:0]  code;
   rsp_type            cr_u, lf_u, pair_u, lone_u;
   rsp_type            res [2];

   always_comb begin
      s       = conv_of(cfg.source_convention);
      d       = conv_of(cfg.dest_convention);
      le      = le_ff;
      seen_in = seen_ff;
      held    = held_ff;
      done    = 1'b0;
      n       = COUNT_NONE;
      res[0]  = '0;
      res[1]  = '0;
      is_two  = item.byte_count[1];

      if (item.byte_count != COUNT_NONE && !seen_ff) begin
         le      = is_two && item.first_byte == BOM_FIRST && item.second_byte == BOM_SECOND;
         seen_in = 1'b1;
      end

      code   = le ? {item.second_byte, item.first_byte}
                  : {item.first_byte, item.second_byte};
      cr_u   = make_code(CODE_CR, le, cfg.swap_order);
      lf_u   = make_code(CODE_LF, le, cfg.swap_order);
      pair_u = make_pair(item.first_byte, item.second_byte, cfg.swap_order);
      lone_u = '0;
      lone_u.out_first_byte = item.first_byte;
      lone_u.out_byte_count = COUNT_ONE;

      if (item.byte_count == COUNT_ONE) begin
         if (held) begin
            res[n[0]] = cr_u;
            n         = n + 1'b1;
            held      = 1'b0;
         end
         res[n[0]] = lone_u;
         n         = n + 1'b1;
      end else if (is_two) begin
         if (held) begin
            held = 1'b0;
            if (s != CONV_WIN || s == d) begin
               res[0] = cr_u;
               res[1] = pair_u;
               n      = COUNT_TWO;
               done   = 1'b1;
            end else if (code == CODE_LF) begin
               // CR LF pair collapses into one destination newline
               if (d == CONV_MAC) begin
                  res[0] = cr_u;
                  n      = COUNT_ONE;
               end else begin
                  res[0] = lf_u;
                  n      = COUNT_ONE;
               end
               done = 1'b1;
            end else begin
               res[0] = cr_u;
               n      = COUNT_ONE;
            end
         end
         if (!done) begin
            if (s == d) begin
               res[n[0]] = pair_u;
               n         = n + 1'b1;
            end else if (s == CONV_WIN) begin
               if (code == CODE_CR) begin
                  held = 1'b1;
               end else begin
                  res[n[0]] = pair_u;
                  n         = n + 1'b1;
               end
            end else if (code == ((s == CONV_UNIX) ? CODE_LF : CODE_CR)) begin
               if (d == CONV_WIN) begin
                  res[0] = cr_u;
                  res[1] = lf_u;
                  n      = COUNT_TWO;
               end else begin
                  res[0] = (d == CONV_MAC) ? cr_u : lf_u;
                  n      = COUNT_ONE;
               end
            end else begin
               res[n[0]] = pair_u;
               n         = n + 1'b1;
            end
         end
      end

      if (item.stream_end) begin
         if (held) begin
            res[n[0]] = cr_u;
            n         = n + 1'b1;
            held      = 1'b0;
         end
         seen_in = 1'b0;
      end

      res[0].last_of_run = (n == COUNT_ONE);
      res[0].end_marker  = (n == COUNT_ONE) && item.stream_end;
      res[1].last_of_run = 1'b1;
      res[1].end_marker  = item.stream_end;

      le_in   = le;
      held_in = held;
   end

   assign take          = item_valid && (n == COUNT_NONE || out_free);
   assign bundle.load   = take && n != COUNT_NONE;
   assign bundle.count  = n;
   assign bundle.res0   = res[0];
   assign bundle.res1   = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         le_ff   <= 1'b0;
         held_ff <= 1'b0;
      end else if (take) begin
         seen_ff <= seen_in;
         le_ff   <= le_in;
         held_ff <= held_in;
      end
   end
endmodule

[sv/ucnv_out_buf.sv]
// ----------------------------------------------------------------------------
// Output buffer
// Holds up to two emitted units and presents them one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module ucnv_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  ucnv_pkg::bundle_type bundle,
   output logic                 out_free,
   ucnv_rsp_if.source           rsp
);
   import ucnv_pkg::*;

   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   rsp_type            slot0_ff, slot0_in;
   rsp_type            slot1_ff, slot1_in;
   logic               pop;

   assign pop      = rsp.valid && rsp.ready;
   // Free when empty, or when the last held unit leaves this cycle
   assign out_free = (cnt_ff == COUNT_NONE) || (cnt_ff == COUNT_ONE && rsp.ready);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (bundle.load) begin
         cnt_in   = bundle.count;
         slot0_in = bundle.res0;
         slot1_in = bundle.res1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 1'b1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= COUNT_NONE;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp.valid           = cnt_ff != COUNT_NONE;
   assign rsp.out_first_byte  = slot0_ff.out_first_byte;
   assign rsp.out_second_byte = slot0_ff.out_second_byte;
   assign rsp.out_byte_count  = slot0_ff.out_byte_count;
   assign rsp.last_of_run     = slot0_ff.last_of_run;
   assign rsp.end_marker      = slot0_ff.end_marker;
endmodule

[bench/utf16_newline_converter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-16 newline converter testbench
// Drives code units through the request channel under several newline and
// swap settings, mirrors the conversion in a local model and checks every
// emitted unit in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module utf16_newline_converter_tb;
   import ucnv_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SEGMENT_UNITS = 90;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ucnv_req_if req_ch();
   ucnv_rsp_if rsp_ch();

   utf16_newline_converter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirrored registers and conversion state
   logic [CONV_W-1:0] cfg_src;
   logic [CONV_W-1:0] cfg_dst;
   logic              cfg_swap;
   logic              seen_first;
   logic              little_end;
   logic              held_cr;

   rsp_type run_units[$];
   rsp_type expected_units[$];

   int send_idle_pct;
   int stall_pct;
   int error_count;
   int units_sent;
   int cycle_count = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.out_first_byte  = rsp_ch.out_first_byte;
         got.out_second_byte = rsp_ch.out_second_byte;
         got.out_byte_count  = rsp_ch.out_byte_count;
         got.last_of_run     = rsp_ch.last_of_run;
         got.end_marker      = rsp_ch.end_marker;
         if (expected_units.size() == 0) begin
            note_error($sformatf("unexpected unit %h %h cnt %0d last %0b end %0b",
                       got.out_first_byte, got.out_second_byte, got.out_byte_count,
                       got.last_of_run, got.end_marker));
         end else begin
            want = expected_units.pop_front();
            if (got !== want) begin
               note_error($sformatf({"mismatch: expected %h %h cnt %0d last %0b end %0b,",
                          " got %h %h cnt %0d last %0b end %0b"},
                          want.out_first_byte, want.out_second_byte, want.out_byte_count,
                          want.last_of_run, want.end_marker,
                          got.out_first_byte, got.out_second_byte, got.out_byte_count,
                          got.last_of_run, got.end_marker));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Conversion model
   // ------------------------------------------------------------------
   function automatic conv_type as_conv(input logic [CONV_W-1:0] v);
      if (v == 2'd3) begin
         return CONV_UNIX;
      end
      return conv_type'(v);
   endfunction

   function automatic void push_unit(input logic [7:0] a, input logic [7:0] b);
      rsp_type u;
      u.out_first_byte  = cfg_swap ? b : a;
      u.out_second_byte = cfg_swap ? a : b;
      u.out_byte_count  = COUNT_TWO;
      u.last_of_run     = 1'b0;
      u.end_marker      = 1'b0;
      run_units.push_back(u);
   endfunction

   function automatic void push_code(input logic [CODE_W-1:0] code);
      if (little_end) begin
         push_unit(code[7:0], code[15:8]);
      end else begin
         push_unit(code[15:8], code[7:0]);
      end
   endfunction

   function automatic void push_newline(input conv_type d);
      if (d == CONV_WIN) begin
         push_code(CODE_CR);
         push_code(CODE_LF);
      end else begin
         push_code(d == CONV_MAC ? CODE_CR : CODE_LF);
      end
   endfunction

   function automatic void convert_request(input req_type rq);
      conv_type          s;
      conv_type          d;
      logic [CODE_W-1:0] code;
      logic              done;
      rsp_type           u;
      s = as_conv(cfg_src);
      d = as_conv(cfg_dst);
      run_units.delete();
      if (rq.byte_count != COUNT_NONE && !seen_first) begin
         little_end = (rq.byte_count >= COUNT_TWO) && rq.first_byte == BOM_FIRST &&
                      rq.second_byte == BOM_SECOND;
         seen_first = 1'b1;
      end
      if (rq.byte_count == COUNT_ONE) begin
         if (held_cr) begin
            push_code(CODE_CR);
            held_cr = 1'b0;
         end
         u = '0;
         u.out_first_byte = rq.first_byte;
         u.out_byte_count = COUNT_ONE;
         run_units.push_back(u);
      end else if (rq.byte_count != COUNT_NONE) begin
         code = little_end ? {rq.second_byte, rq.first_byte}
                           : {rq.first_byte, rq.second_byte};
         done = 1'b0;
         if (held_cr) begin
            held_cr = 1'b0;
            if (s != CONV_WIN || s == d) begin
               push_code(CODE_CR);
               push_unit(rq.first_byte, rq.second_byte);
               done = 1'b1;
            end else if (code == CODE_LF) begin
               push_newline(d);
               done = 1'b1;
            end else begin
               push_code(CODE_CR);
            end
         end
         if (!done) begin
            if (s == d) begin
               push_unit(rq.first_byte, rq.second_byte);
            end else if (s == CONV_WIN) begin
               if (code == CODE_CR) begin
                  held_cr = 1'b1;
               end else begin
                  push_unit(rq.first_byte, rq.second_byte);
               end
            end else if (code == ((s == CONV_UNIX) ? CODE_LF : CODE_CR)) begin
               push_newline(d);
            end else begin
               push_unit(rq.first_byte, rq.second_byte);
            end
         end
      end
      if (rq.stream_end) begin
         if (held_cr) begin
            push_code(CODE_CR);
            held_cr = 1'b0;
         end
         seen_first = 1'b0;
      end
      if (run_units.size() > 0) begin
         u = run_units.pop_back();
         u.last_of_run = 1'b1;
         u.end_marker  = rq.stream_end;
         run_units.push_back(u);
      end
      foreach (run_units[i]) begin
         expected_units.push_back(run_units[i]);
      end
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   task automatic send_unit(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [COUNT_W-1:0] cnt, input logic fin);
      req_type rq;
      rq.first_byte  = b0;
      rq.second_byte = b1;
      rq.byte_count  = cnt;
      rq.stream_end  = fin;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.first_byte  <= b0;
      req_ch.second_byte <= b1;
      req_ch.byte_count  <= cnt;
      req_ch.stream_end  <= fin;
      do @(posedge clock); while (!req_ch.ready);
      convert_request(rq);
      if (cnt != COUNT_NONE) begin
         units_sent++;
      end
   endtask

   // Place a code in the byte order of the stream being built
   task automatic send_code(input logic [CODE_W-1:0] code, input logic little,
                            input logic fin);
      if (little) begin
         send_unit(code[7:0], code[15:8], COUNT_TWO, fin);
      end else begin
         send_unit(code[15:8], code[7:0], COUNT_TWO, fin);
      end
   endtask

   // Drop valid and let every pending unit come out before touching registers
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_units.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] src,
                             input logic [CSR_DATA_W-1:0] dst,
                             input logic [CSR_DATA_W-1:0] swp);
      csr_we    <= 1'b1;
      csr_index <= CSR_SOURCE;
      csr_wdata <= src;
      @(posedge clock);
      csr_index <= CSR_DEST;
      csr_wdata <= dst;
      @(posedge clock);
      csr_index <= CSR_SWAP;
      csr_wdata <= swp;
      @(posedge clock);
      csr_we   <= 1'b0;
      cfg_src  = src;
      cfg_dst  = dst;
      cfg_swap = swp[0];
   endtask

   task automatic send_stream();
      logic              little;
      logic [7:0]        b0;
      logic [7:0]        b1;
      logic [CODE_W-1:0] code;
      int                len;
      little = 1'b0;
      case ($urandom_range(3))
         0: begin
            little = 1'b1;
            send_unit(BOM_FIRST, BOM_SECOND, COUNT_TWO, 1'b0);
         end
         1: send_unit(BOM_SECOND, BOM_FIRST, COUNT_TWO, 1'b0);
         2: ;
         default: begin
            b0 = 8'($urandom);
            b1 = 8'($urandom);
            little = (b0 == BOM_FIRST && b1 == BOM_SECOND);
            send_unit(b0, b1, COUNT_TWO, 1'b0);
         end
      endcase
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(9))
            0, 1: send_code(CODE_CR, little, 1'b0);
            2, 3: send_code(CODE_LF, little, 1'b0);
            4, 5: begin
               send_code(CODE_CR, little, 1'b0);
               send_code(CODE_LF, little, 1'b0);
            end
            // newline bytes in the wrong order must pass as plain text
            6: send_code($urandom_range(1) ? 16'h0D00 : 16'h0A00, little, 1'b0);
            default: send_code(16'($urandom), little, 1'b0);
         endcase
      end
      case ($urandom_range(5))
         0: send_unit(8'($urandom), 8'($urandom), COUNT_ONE, 1'b1);
         1: send_unit(8'($urandom), 8'($urandom), COUNT_NONE, 1'b1);
         2: send_code(CODE_CR, little, 1'b1);
         3: send_code(CODE_LF, little, 1'b1);
         default: send_code(16'($urandom), little, 1'b1);
      endcase
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_reset_passthrough();
      send_unit(BOM_FIRST, BOM_SECOND, COUNT_TWO, 1'b0);
      send_unit(8'h00, 8'h00, COUNT_TWO, 1'b0);
      send_unit(8'hFF, 8'hFF, COUNT_TWO, 1'b0);
      send_unit(8'hA5, 8'h3C, COUNT_ONE, 1'b1);
      wait_idle();
   endtask

   task automatic test_lf_expansion();
      set_config(CONV_UNIX, CONV_WIN, 2'd1);
      send_unit(8'h00, 8'h0A, COUNT_TWO, 1'b0);
      send_unit(8'h00, 8'h41, COUNT_TWO, 1'b1);
      wait_idle();
   endtask

   task automatic test_windows_source();
      set_config(CONV_WIN, CONV_UNIX, 2'd0);
      send_unit(BOM_FIRST, BOM_SECOND, COUNT_TWO, 1'b0);
      send_unit(8'h0D, 8'h00, COUNT_TWO, 1'b0);
      send_unit(8'h0A, 8'h00, COUNT_TWO, 1'b0);
      send_unit(8'h0D, 8'h00, COUNT_TWO, 1'b0);
      send_unit(8'h41, 8'h00, COUNT_TWO, 1'b0);
      send_unit(8'h0D, 8'h00, COUNT_TWO, 1'b0);
      send_unit(8'h0D, 8'h00, COUNT_TWO, 1'b0);
      send_unit(8'h7E, 8'h00, COUNT_ONE, 1'b0);
      send_unit(8'h0D, 8'h00, COUNT_TWO, 1'b0);
      send_unit(8'h00, 8'h00, COUNT_NONE, 1'b1);
      wait_idle();
   endtask

   task automatic test_config_while_held();
      set_config(CONV_WIN, CONV_MAC, 2'd0);
      send_unit(8'h00, 8'h0D, COUNT_TWO, 1'b0);
      wait_idle();
      set_config(CONV_UNIX, CONV_MAC, 2'd0);
      send_unit(8'h00, 8'h0A, COUNT_TWO, 1'b1);
      wait_idle();
      set_config(CONV_WIN, CONV_UNIX, 2'd0);
      send_unit(8'h00, 8'h0D, COUNT_TWO, 1'b0);
      wait_idle();
      set_config(CONV_WIN, CONV_WIN, 2'd0);
      send_unit(8'h00, 8'h41, COUNT_TWO, 1'b1);
      wait_idle();
   endtask

   task automatic test_odd_codes();
      // convention three reads as unix, swap data three as swap on
      set_config(2'd3, CONV_WIN, 2'd3);
      send_unit(8'h00, 8'h0A, COUNT_TWO, 1'b1);
      wait_idle();
      set_config(CONV_MAC, CONV_WIN, 2'd0);
      send_unit(8'h00, 8'h0D, 2'd3, 1'b1);
      wait_idle();
      set_config(CONV_WIN, 2'd3, 2'd0);
      send_unit(8'h00, 8'h0D, COUNT_TWO, 1'b0);
      send_unit(8'h00, 8'h0A, 2'd3, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall);
      int target;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int seg = 0; seg < 6; seg++) begin
         set_config(2'($urandom_range(3)), 2'($urandom_range(3)), 2'($urandom_range(3)));
         target = units_sent + SEGMENT_UNITS;
         while (units_sent < target) begin
            if ($urandom_range(9) == 0) begin
               send_unit(8'($urandom), 8'($urandom), 2'($urandom_range(3)),
                         $urandom_range(7) == 0);
            end else begin
               send_stream();
            end
         end
         wait_idle();
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = CSR_SOURCE;
      csr_wdata    = '0;
      req_ch.valid       = 1'b0;
      req_ch.first_byte  = '0;
      req_ch.second_byte = '0;
      req_ch.byte_count  = COUNT_TWO;
      req_ch.stream_end  = 1'b0;
      cfg_src      = CONV_UNIX;
      cfg_dst      = CONV_UNIX;
      cfg_swap     = 1'b0;
      seen_first   = 1'b0;
      little_end   = 1'b0;
      held_cr      = 1'b0;
      send_idle_pct = 25;
      stall_pct     = 67;
      error_count   = 0;
      units_sent    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_passthrough();
      test_lf_expansion();
      test_windows_source();
      test_config_while_held();
      test_odd_codes();
      test_random_traffic(25, 67);
      test_random_traffic(67, 25);
      test_random_traffic(0, 0);

      wait_idle();
      repeat (20) @(posedge clock);
      if (expected_units.size() != 0) begin
         note_error($sformatf("%0d expected units never arrived", expected_units.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
